// ----- hw/rtl/bdsd_pkg.sv -----
// ----------------------------------------------------------------------------
// bdsd_pkg
// shared widths, register indexes and control types for the 2x2 box
// downsampler
// ----------------------------------------------------------------------------
package bdsd_pkg;

  localparam int CHAN_W            = 8;
  localparam int PAIR_W            = 10;
  localparam int LANES             = 4;
  localparam int LINE_W            = LANES * PAIR_W;
  localparam int DIM_W             = 13;
  localparam int ROW_W             = 12;
  localparam int HEIGHT_LIMIT      = 4096;
  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int CFG_INDEX_W       = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = CFG_INDEX_W'(1);

  // what one accepted pixel does
  typedef struct packed {
    logic w_one;   // width of one, pixel counts twice across
    logic h_one;   // height of one, pair counts twice down
    logic hold;    // left pixel of a horizontal pair
    logic pair;    // pair sum formed on this pixel
    logic wr;      // pair sum goes to the line store
    logic emit;    // block complete, result leaves
    logic last;    // final destination pixel of the image
  } step_t;

endpackage

// ----- hw/rtl/bdsd_ifs.sv -----
// ----------------------------------------------------------------------------
// bdsd interfaces
// pixel, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface bdsd_pix_if;
  logic                        valid;
  logic                        ready;
  logic [bdsd_pkg::CHAN_W-1:0] red;
  logic [bdsd_pkg::CHAN_W-1:0] green;
  logic [bdsd_pkg::CHAN_W-1:0] blue;
  logic [bdsd_pkg::CHAN_W-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface bdsd_res_if;
  logic                        valid;
  logic                        ready;
  logic [bdsd_pkg::CHAN_W-1:0] out_red;
  logic [bdsd_pkg::CHAN_W-1:0] out_green;
  logic [bdsd_pkg::CHAN_W-1:0] out_blue;
  logic [bdsd_pkg::CHAN_W-1:0] out_alpha;
  logic                        last_pixel;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, last_pixel,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, last_pixel,
                  output ready);
endinterface

interface bdsd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bdsd_pkg::CFG_INDEX_W-1:0] index;
  logic [bdsd_pkg::DIM_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/bdsd_line_store.sv -----
// ----------------------------------------------------------------------------
// bdsd_line_store
// line memory of horizontal pair sums, one write and one registered read
// ----------------------------------------------------------------------------
module bdsd_line_store #(
  parameter int DEPTH = bdsd_pkg::MAX_WIDTH_DEFAULT / 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic                        re,
  input  logic [AW-1:0]               addr,
  input  logic [bdsd_pkg::LINE_W-1:0] wdata,
  output logic [bdsd_pkg::LINE_W-1:0] rdata
);

  logic [bdsd_pkg::LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- hw/rtl/bdsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdsd_ctrl
// configuration registers and source position counters; decodes what each
// accepted pixel does
// ----------------------------------------------------------------------------
module bdsd_ctrl #(
  parameter int MAX_WIDTH = bdsd_pkg::MAX_WIDTH_DEFAULT,
  parameter int AW        = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  bdsd_cfg_if.sink             cfg,
  input  logic                 accept,
  output bdsd_pkg::step_t      step,
  output logic [AW-1:0]        addr
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = CW + 1;
  localparam int HW = bdsd_pkg::DIM_W;
  localparam int RW = bdsd_pkg::ROW_W;

  logic [WW-1:0] width;
  logic [WW-1:0] dst_width;
  logic [HW-1:0] height;
  logic [HW-1:0] dst_height;
  logic [CW-1:0] column;
  logic [RW-1:0] row;

  logic          cfg_write;
  logic          cfg_hit;
  logic [WW-1:0] width_next;
  logic [HW-1:0] height_next;
  logic          x_last;
  logic          y_last;
  logic          col_drop;
  logic          row_drop;
  logic [WW-1:0] px;
  logic [HW-1:0] py;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid & cfg.ready;
  assign cfg_hit   = (cfg.index == bdsd_pkg::REG_SRC_WIDTH) ||
                     (cfg.index == bdsd_pkg::REG_SRC_HEIGHT);

  // zero reads as one, oversize saturates
  always_comb begin
    if (cfg.data == '0) begin
      width_next  = WW'(1);
      height_next = HW'(1);
    end else begin
      if (32'(cfg.data) > MAX_WIDTH) begin
        width_next = WW'(MAX_WIDTH);
      end else begin
        width_next = WW'(cfg.data);
      end
      if (32'(cfg.data) > bdsd_pkg::HEIGHT_LIMIT) begin
        height_next = HW'(bdsd_pkg::HEIGHT_LIMIT);
      end else begin
        height_next = cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width      <= WW'(1);
      dst_width  <= WW'(1);
      height     <= HW'(1);
      dst_height <= HW'(1);
      column     <= '0;
      row        <= '0;
    end else if (cfg_write) begin
      if (cfg.index == bdsd_pkg::REG_SRC_WIDTH) begin
        width     <= width_next;
        dst_width <= (width_next == WW'(1)) ? WW'(1) : (width_next >> 1);
      end
      if (cfg.index == bdsd_pkg::REG_SRC_HEIGHT) begin
        height     <= height_next;
        dst_height <= (height_next == HW'(1)) ? HW'(1) : (height_next >> 1);
      end
      if (cfg_hit) begin
        column <= '0;
        row    <= '0;
      end
    end else if (accept) begin
      if (x_last) begin
        column <= '0;
        row    <= y_last ? '0 : row + RW'(1);
      end else begin
        column <= column + CW'(1);
      end
    end
  end

  assign x_last   = (WW'(column) == width - WW'(1));
  assign y_last   = (HW'(row) == height - HW'(1));
  assign col_drop = width[0] & x_last & ~step.w_one;
  assign row_drop = height[0] & y_last & ~step.h_one;
  assign px       = WW'(column >> 1);
  assign py       = HW'(row >> 1);
  assign addr     = px[AW-1:0];

  always_comb begin
    step.w_one = (width == WW'(1));
    step.h_one = (height == HW'(1));
    step.hold  = ~step.w_one & ~col_drop & ~column[0];
    step.pair  = step.w_one | (~col_drop & column[0]);
    step.wr    = step.pair & ~step.h_one & ~row_drop & ~row[0];
    step.emit  = step.pair & (step.h_one | (~row_drop & row[0]));
    step.last  = (px == dst_width - WW'(1)) &&
                 (step.h_one || (py == dst_height - HW'(1)));
  end

endmodule

// ----- hw/rtl/bdsd_lane.sv -----
// ----------------------------------------------------------------------------
// bdsd_lane
// one colour channel: horizontal pair sum, vertical block sum and rounding
// ----------------------------------------------------------------------------
module bdsd_lane (
  input  logic                          clk,
  input  logic                          accept,
  input  bdsd_pkg::step_t               step,
  input  logic [bdsd_pkg::CHAN_W-1:0]   pixel,
  input  logic                          blk_h_one,
  input  logic [bdsd_pkg::PAIR_W-1:0]   line_sum,
  input  logic                          load_out,
  output logic [bdsd_pkg::PAIR_W-1:0]   pair_sum,
  output logic [bdsd_pkg::CHAN_W-1:0]   result
);

  localparam int PW = bdsd_pkg::PAIR_W;
  localparam int TW = PW + 1;

  logic [bdsd_pkg::CHAN_W-1:0] held;
  logic [PW-1:0]               pair_reg;
  logic [TW-1:0]               total;
  logic [TW-1:0]               rounded;

  always_comb begin
    if (step.w_one) begin
      pair_sum = PW'(pixel) << 1;
    end else begin
      pair_sum = PW'(held) + PW'(pixel);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && step.hold) begin
      held <= pixel;
    end
    if (accept) begin
      pair_reg <= pair_sum;
    end
  end

  // a single row uses its pair sum twice
  assign total   = blk_h_one ? (TW'(pair_reg) << 1) : (TW'(line_sum) + TW'(pair_reg));
  assign rounded = (total + TW'(2)) >> 2;

  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= rounded[bdsd_pkg::CHAN_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/box_downsample_2x2_unit.sv -----
// ----------------------------------------------------------------------------
// box_downsample_2x2_unit
// streaming 2x2 box-filter downsampler for rgba pixels in raster order
// ----------------------------------------------------------------------------
// Takes one source pixel per clock unless the output stalls and gives one
// result for every 2x2 block; the rate is set by a single-port line store
// of MAX_WIDTH/2 entries of 40 bits that is written on even rows and read
// on odd rows, at most one access per pixel. Four channel lanes run side
// by side and an output register merges their means with the last-pixel
// flag. The line store needs no clearing after reset: an entry is always
// written on an even row before its odd row reads it. Size writes restart
// the image. Configuration writes belong to idle periods only.
module box_downsample_2x2_unit #(
  parameter int MAX_WIDTH = bdsd_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  bdsd_pix_if.sink    src,
  bdsd_res_if.source  dst,
  bdsd_cfg_if.sink    cfg
);

  localparam int DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = bdsd_pkg::PAIR_W;
  localparam int NL    = bdsd_pkg::LANES;

  bdsd_pkg::step_t             step;
  logic [AW-1:0]               addr;
  logic                        accept;
  logic                        blk_valid;
  logic                        blk_h_one;
  logic                        blk_last;
  logic                        blk_adv;
  logic                        out_adv;
  logic                        load_out;
  logic [bdsd_pkg::LINE_W-1:0] line_wdata;
  logic [bdsd_pkg::LINE_W-1:0] line_rdata;
  logic [bdsd_pkg::CHAN_W-1:0] lane_pixel  [NL];
  logic [bdsd_pkg::CHAN_W-1:0] lane_result [NL];

  assign out_adv   = ~dst.valid | dst.ready;
  assign blk_adv   = ~blk_valid | out_adv;
  assign src.ready = blk_adv;
  assign accept    = src.valid & src.ready;
  assign load_out  = out_adv & blk_valid;

  assign lane_pixel[0] = src.red;
  assign lane_pixel[1] = src.green;
  assign lane_pixel[2] = src.blue;
  assign lane_pixel[3] = src.alpha;

  bdsd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .step   (step),
    .addr   (addr)
  );

  bdsd_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line (
    .clk   (clk),
    .we    (accept & step.wr),
    .re    (accept & step.emit & ~step.h_one),
    .addr  (addr),
    .wdata (line_wdata),
    .rdata (line_rdata)
  );

  for (genvar g = 0; g < NL; g++) begin : g_lane
    bdsd_lane u_lane (
      .clk       (clk),
      .accept    (accept),
      .step      (step),
      .pixel     (lane_pixel[g]),
      .blk_h_one (blk_h_one),
      .line_sum  (line_rdata[g*PW +: PW]),
      .load_out  (load_out),
      .pair_sum  (line_wdata[g*PW +: PW]),
      .result    (lane_result[g])
    );
  end

  // block stage: only pixels that complete a block occupy it
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (blk_adv) begin
      blk_valid <= accept & step.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_h_one <= step.h_one;
      blk_last  <= step.last;
    end
  end

  // output register merges the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      dst.valid <= 1'b0;
    end else if (out_adv) begin
      dst.valid <= blk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      dst.last_pixel <= blk_last;
    end
  end

  assign dst.out_red   = lane_result[0];
  assign dst.out_green = lane_result[1];
  assign dst.out_blue  = lane_result[2];
  assign dst.out_alpha = lane_result[3];

endmodule

// ----- dv/box_downsample_2x2_unit_tb.sv -----
// ----------------------------------------------------------------------------
// box_downsample_2x2_unit_tb
// self-checking bench for the streaming 2x2 box downsampler: directed cases
// for rounding, odd and unit dimensions, register limits and restarts, then
// random images of random size under bursty input and a stalling output
// ----------------------------------------------------------------------------
module box_downsample_2x2_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAN_W       = bdsd_pkg::CHAN_W;
  localparam int PAIR_W       = bdsd_pkg::PAIR_W;
  localparam int LANES        = bdsd_pkg::LANES;
  localparam int DIM_W        = bdsd_pkg::DIM_W;
  localparam int CFG_INDEX_W  = bdsd_pkg::CFG_INDEX_W;
  localparam int HEIGHT_LIMIT = bdsd_pkg::HEIGHT_LIMIT;

  localparam int MAX_W          = bdsd_pkg::MAX_WIDTH_DEFAULT;
  localparam int LINE_DEPTH     = MAX_W / 2;
  localparam int LINE_AW        = $clog2(LINE_DEPTH);
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int MAX_REPORTS    = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = bdsd_pkg::REG_SRC_HEIGHT + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_TOP    = '1;

  typedef enum int {ALWAYS_READY, LIGHT_STALL, HEAVY_STALL, LONG_STALL} stall_mode_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              last;
  } block_mean_t;

  logic clk;
  logic rst;

  bdsd_pix_if pix_if ();
  bdsd_res_if res_if ();
  bdsd_cfg_if cfg_if ();

  box_downsample_2x2_unit u_top (
    .clk (clk),
    .rst (rst),
    .src (pix_if),
    .dst (res_if),
    .cfg (cfg_if)
  );

  // predictor state
  logic [DIM_W-1:0]                width_reg  = 1;
  logic [DIM_W-1:0]                height_reg = 1;
  int unsigned                     col_pos    = 0;
  int unsigned                     row_pos    = 0;
  pixel_t                          left_pixel = '0;
  logic [LANES-1:0][PAIR_W-1:0]    pair_sums [LINE_DEPTH];

  block_mean_t expected_means [$];
  int          mismatches   = 0;
  int          pixels_sent  = 0;
  int          burst_left   = 0;
  int          idle_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned limit);
    if (v == 0) return 1;
    if (32'(v) > limit) return limit;
    return 32'(v);
  endfunction

  function automatic void predict_pixel(pixel_t p);
    int unsigned       w, h, dw, dh, px, py, total;
    logic [CHAN_W-1:0] cur [LANES];
    logic [CHAN_W-1:0] left [LANES];
    logic [CHAN_W-1:0] mean [LANES];
    logic [LANES-1:0][PAIR_W-1:0] pair;
    bit                have_pair, emit;
    block_mean_t       m;
    w  = clamp_dim(width_reg, MAX_W);
    h  = clamp_dim(height_reg, HEIGHT_LIMIT);
    dw = (w > 1) ? w / 2 : 1;
    dh = (h > 1) ? h / 2 : 1;
    cur  = '{p.red, p.green, p.blue, p.alpha};
    left = '{left_pixel.red, left_pixel.green, left_pixel.blue, left_pixel.alpha};
    have_pair = 1'b0;
    emit      = 1'b0;
    px = 0;
    py = 0;
    pair = '0;
    if (w == 1) begin
      for (int c = 0; c < LANES; c++) pair[c] = PAIR_W'(2 * cur[c]);
      have_pair = 1'b1;
    end else if (col_pos < 2 * dw) begin
      px = col_pos / 2;
      if (col_pos % 2 == 0) begin
        left_pixel = p;
      end else begin
        for (int c = 0; c < LANES; c++) pair[c] = PAIR_W'(left[c]) + PAIR_W'(cur[c]);
        have_pair = 1'b1;
      end
    end
    if (have_pair && px < LINE_DEPTH) begin
      if (h == 1) begin
        emit = 1'b1;
        for (int c = 0; c < LANES; c++) mean[c] = CHAN_W'((2 * pair[c] + 2) >> 2);
      end else if (row_pos < 2 * dh) begin
        py = row_pos / 2;
        if (row_pos % 2 == 0) begin
          pair_sums[px[LINE_AW-1:0]] = pair;
        end else begin
          emit = 1'b1;
          for (int c = 0; c < LANES; c++) begin
            total   = 32'(pair_sums[px[LINE_AW-1:0]][c]) + 32'(pair[c]);
            mean[c] = CHAN_W'((total + 2) >> 2);
          end
        end
      end
    end
    if (emit) begin
      m = '{mean[0], mean[1], mean[2], mean[3], (px == dw - 1) && (py == dh - 1)};
      expected_means.insert(expected_means.size(), m);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // pixel source: bursts of random length with random gaps
  task automatic send_pixel(input pixel_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_if.valid <= 1'b1;
    pix_if.red   <= p.red;
    pix_if.green <= p.green;
    pix_if.blue  <= p.blue;
    pix_if.alpha <= p.alpha;
    do @(posedge clk); while (!pix_if.ready);
    pixels_sent++;
    predict_pixel(p);
  endtask

  task automatic send_random_pixels(input int n);
    repeat (n) send_pixel(pixel_t'($urandom()));
  endtask

  // lets the block empty out, including pixels in flight that give no result
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [DIM_W-1:0] value);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == bdsd_pkg::REG_SRC_WIDTH || idx == bdsd_pkg::REG_SRC_HEIGHT) begin
      if (idx == bdsd_pkg::REG_SRC_WIDTH) width_reg = value;
      else height_reg = value;
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic set_image(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_register(bdsd_pkg::REG_SRC_WIDTH, w);
    write_register(bdsd_pkg::REG_SRC_HEIGHT, h);
  endtask

  task automatic test_reset_state();
    // width and height of one after reset: every pixel is its own block
    send_random_pixels(1);
    write_register(bdsd_pkg::REG_SRC_WIDTH, '0);
    write_register(bdsd_pkg::REG_SRC_HEIGHT, '0);
    send_random_pixels(1);
  endtask

  task automatic test_rounding();
    set_image(DIM_W'(2), DIM_W'(2));
    send_pixel('{8'd0, 8'd0, 8'd0, 8'hff});
    send_pixel('{8'd0, 8'd0, 8'd1, 8'hff});
    send_pixel('{8'd0, 8'd1, 8'd1, 8'hff});
    send_pixel('{8'd1, 8'd1, 8'd1, 8'hff});
  endtask

  task automatic test_odd_dimensions();
    set_image(DIM_W'(3), DIM_W'(3));
    send_random_pixels(9);
  endtask

  task automatic test_unit_dimensions();
    set_image(DIM_W'(1), DIM_W'(2));
    send_random_pixels(2);
    set_image(DIM_W'(2), DIM_W'(1));
    send_random_pixels(2);
  endtask

  task automatic test_restart_and_ignored_index();
    set_image(DIM_W'(2), DIM_W'(2));
    send_random_pixels(3);
    // same value again still restarts the image
    write_register(bdsd_pkg::REG_SRC_WIDTH, DIM_W'(2));
    send_random_pixels(2);
    write_register(REG_FIRST_UNUSED, '1);
    write_register(REG_INDEX_TOP, '0);
    send_random_pixels(2);
  endtask

  task automatic test_register_limits();
    set_image('1, DIM_W'(1));
    send_random_pixels(2);
    set_image(DIM_W'(1), '1);
    send_random_pixels(2);
    set_image(DIM_W'(MAX_W), DIM_W'(HEIGHT_LIMIT));
    send_random_pixels(4);
  endtask

  task automatic test_random_images();
    int w, h, n;
    while (pixels_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(17, 160);
          h = $urandom_range(1, 3);
        end
        1: begin
          w = $urandom_range(1, 3);
          h = $urandom_range(9, 40);
        end
        default: begin
          w = $urandom_range(1, 12);
          h = $urandom_range(1, 8);
        end
      endcase
      set_image(DIM_W'(w), DIM_W'(h));
      repeat ($urandom_range(1, 3)) send_random_pixels(w * h);
      // broken image, cut short by the next register write
      if ($urandom_range(0, 5) == 0) begin
        n = (w * h > 1) ? int'($urandom_range(1, w * h - 1)) : 1;
        send_random_pixels(n);
      end
      if ($urandom_range(0, 7) == 0)
        write_register(CFG_INDEX_W'($urandom_range(REG_FIRST_UNUSED, REG_INDEX_TOP)),
                       DIM_W'($urandom()));
    end
  endtask

  initial begin
    rst          <= 1'b1;
    pix_if.valid <= 1'b0;
    pix_if.red   <= '0;
    pix_if.green <= '0;
    pix_if.blue  <= '0;
    pix_if.alpha <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_rounding();
    test_odd_dimensions();
    test_unit_dimensions();
    test_restart_and_ignored_index();
    test_register_limits();
    test_random_images();
    drain_results();
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // result sink stalls on a pattern of its own
  initial begin
    stall_mode_t mode;
    int          stretch;
    res_if.ready <= 1'b0;
    forever begin
      mode    = stall_mode_t'($urandom_range(0, 3));
      stretch = $urandom_range(10, 120);
      repeat (stretch) begin
        @(posedge clk);
        case (mode)
          ALWAYS_READY: res_if.ready <= 1'b1;
          LIGHT_STALL:  res_if.ready <= ($urandom_range(0, 3) != 0);
          HEAVY_STALL:  res_if.ready <= ($urandom_range(0, 3) == 0);
          default:      res_if.ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    block_mean_t got, want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = '{res_if.out_red, res_if.out_green, res_if.out_blue, res_if.out_alpha,
              res_if.last_pixel};
      if (expected_means.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result r=%0d g=%0d b=%0d a=%0d last=%0b",
                   got.red, got.green, got.blue, got.alpha, got.last);
        mismatches++;
      end else begin
        want = expected_means.pop_front();
        if (got.red != want.red || got.green != want.green || got.blue != want.blue ||
            got.alpha != want.alpha || got.last != want.last) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch exp r%0d g%0d b%0d a%0d l%0b got r%0d g%0d b%0d a%0d l%0b",
                     want.red, want.green, want.blue, want.alpha, want.last,
                     got.red, got.green, got.blue, got.alpha, got.last);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
